FILE: src/strict_priority_multi_fifo_assert.svh
// assertion macros for the strict priority queue checker
`ifndef STRICT_PRIORITY_MULTI_FIFO_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_FIFO_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/spmf_pkg.sv
package spmf_pkg;

  // fixed field widths of the words on the ports
  localparam int WORD_W  = 32;
  localparam int CLASS_W = 2;
  localparam int COUNT_W = 4;

  // mode codes
  localparam logic MODE_PUSH = 1'b0;

  // request word
  typedef struct packed {
    logic               mode;
    logic [CLASS_W-1:0] class_in;
    logic [WORD_W-1:0]  payload;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  data_out;
    logic [CLASS_W-1:0] class_out;
    logic [COUNT_W-1:0] class_count;
    logic [WORD_W-1:0]  total_pushed;
    logic [WORD_W-1:0]  total_popped;
    logic [WORD_W-1:0]  total_dropped;
  } out_word_t;

endpackage

FILE: src/spmf_ram.sv
module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/strict_priority_multi_fifo.sv
// path: an accepted word is decided into the stage register s1_q, then moves
//   into the result register when that register is empty or not stalled
// throughput: one push or pop per cycle while not stalled; the ring store has
//   one write, one registered read port; pick and pointer update combinational
// reset: pointers, totals, shutdown and valid flags clear at once; the ring
//   store is not cleared, its slots are only read after a push wrote them
module strict_priority_multi_fifo
  import spmf_pkg::*;
#(
  parameter int RING_DEPTH  = 16,
  parameter int NUM_CLASSES = 4,
  parameter int DATA_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int OCC_W     = PTR_W + 1;
  localparam int RAM_DEPTH = NUM_CLASSES * (2 ** PTR_W);
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // work carried from the decision stage to the result register
  typedef struct packed {
    logic               ok;
    logic               pop_hit;
    logic [CLASS_W-1:0] class_out;
    logic [COUNT_W-1:0] class_count;
    logic [WORD_W-1:0]  total_pushed;
    logic [WORD_W-1:0]  total_popped;
    logic [WORD_W-1:0]  total_dropped;
  } stage_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [OCC_W-1:0] occupancy(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t);
    logic [OCC_W-1:0] d;
    d = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      d = d + OCC_W'(RING_DEPTH);
    end
    occupancy = d;
  endfunction

  logic                  shut_down_q;
  logic [PTR_W-1:0]      head_q [NUM_CLASSES];
  logic [PTR_W-1:0]      head_d [NUM_CLASSES];
  logic [PTR_W-1:0]      tail_q [NUM_CLASSES];
  logic [PTR_W-1:0]      tail_d [NUM_CLASSES];
  logic [WORD_W-1:0]     pushed_q, pushed_d;
  logic [WORD_W-1:0]     popped_q, popped_d;
  logic [WORD_W-1:0]     dropped_q, dropped_d;

  logic                  s1_valid_q, s1_valid_d;
  stage_t                s1_q, s1_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_word_q;

  logic                  in_acc;
  logic                  s1_move;
  logic [CLS_W-1:0]      cls_sat;
  logic [DATA_WIDTH-1:0] word_m;
  logic [NUM_CLASSES-1:0] nonempty;
  logic                  pop_found;
  logic [CLS_W-1:0]      pop_cls;
  logic [PTR_W-1:0]      tail_adv;
  logic [CLS_W-1:0]      res_cls;
  logic [OCC_W-1:0]      res_occ;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // handshake: hold the input while a decided word cannot move on
  assign s1_move    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // class saturation and payload fit
  always_comb begin
    if (int'(in_word_i.class_in) >= NUM_CLASSES) begin
      cls_sat = CLS_W'(NUM_CLASSES - 1);
    end else begin
      cls_sat = CLS_W'(in_word_i.class_in);
    end
  end

  assign word_m = DATA_WIDTH'(in_word_i.payload);

  // highest non-empty class wins
  always_comb begin
    pop_found = 1'b0;
    pop_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (head_q[c] != tail_q[c]);
      if (nonempty[c]) begin
        pop_found = 1'b1;
        pop_cls   = CLS_W'(c);
      end
    end
  end

  assign tail_adv = ptr_inc(tail_q[cls_sat]);

  // push / pop decision and state update
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    pushed_d  = pushed_q;
    popped_d  = popped_q;
    dropped_d = dropped_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = {cls_sat, tail_q[cls_sat]};
    ram_raddr = {pop_cls, head_q[pop_cls]};
    res_cls   = '0;
    s1_d      = '0;

    if (in_acc) begin
      if (in_word_i.mode == MODE_PUSH) begin
        res_cls = cls_sat;
        if (!shut_down_q && word_m != '0) begin
          if (tail_adv == head_q[cls_sat]) begin
            dropped_d = dropped_q + 1'b1;
          end else begin
            ram_we          = 1'b1;
            tail_d[cls_sat] = tail_adv;
            pushed_d        = pushed_q + 1'b1;
            s1_d.ok         = 1'b1;
          end
        end
      end else if (!shut_down_q && pop_found) begin
        ram_re          = 1'b1;
        head_d[pop_cls] = ptr_inc(head_q[pop_cls]);
        popped_d        = popped_q + 1'b1;
        res_cls         = pop_cls;
        s1_d.ok         = 1'b1;
        s1_d.pop_hit    = 1'b1;
      end
    end

    res_occ            = occupancy(head_d[res_cls], tail_d[res_cls]);
    s1_d.class_out     = CLASS_W'(res_cls);
    s1_d.class_count   = COUNT_W'(res_occ);
    s1_d.total_pushed  = pushed_d;
    s1_d.total_popped  = popped_d;
    s1_d.total_dropped = dropped_d;
  end

  // valid flags of the two stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shut_down_q <= 1'b0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      pushed_q    <= '0;
      popped_q    <= '0;
      dropped_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shut_down_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      pushed_q    <= pushed_d;
      popped_q    <= popped_d;
      dropped_q   <= dropped_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // decided word and result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_word_q.ok            <= s1_q.ok;
      out_word_q.data_out      <= s1_q.pop_hit ? WORD_W'(ram_rdata) : '0;
      out_word_q.class_out     <= s1_q.class_out;
      out_word_q.class_count   <= s1_q.class_count;
      out_word_q.total_pushed  <= s1_q.total_pushed;
      out_word_q.total_popped  <= s1_q.total_popped;
      out_word_q.total_dropped <= s1_q.total_dropped;
    end
  end

  // ring store, one region per class
  spmf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (word_m),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: src/spmf_checker.sv
`include "strict_priority_multi_fifo_assert.svh"

module spmf_checker
  import spmf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled result word holds
  `SPMF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled result word changed")

  // a refused request returns no data
  `SPMF_ASSERT_IMP(a_fail_no_data, clk_i, rst_ni, out_valid_o && !out_word_o.ok, out_word_o.data_out == '0, "failed result carries data")

  // input backs up only behind a full, stalled output
  `SPMF_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while output can move")

  // a fresh result traces back to an accepted word
  `SPMF_ASSERT_IMP(a_out_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result without a matching request")

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

FILE: tb/tb_strict_priority_multi_fifo.sv
module tb_strict_priority_multi_fifo;
  import spmf_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int NUM_CLASSES = 4;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic MODE_POP = ~MODE_PUSH;
  localparam logic SHUT_OFF = 1'b0;
  localparam logic SHUT_ON = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // words waiting to be sent and results still owed by the block
  in_word_t request_q[$];
  out_word_t outcome_q[$];

  // shadow of the rings, pointers, totals and shutdown flag
  logic [WORD_W-1:0] ring_mem[NUM_CLASSES][RING_DEPTH];
  logic [PTR_W-1:0] head_ptr[NUM_CLASSES];
  logic [PTR_W-1:0] tail_ptr[NUM_CLASSES];
  logic [WORD_W-1:0] pushed_cnt = '0;
  logic [WORD_W-1:0] popped_cnt = '0;
  logic [WORD_W-1:0] dropped_cnt = '0;
  logic shut_flag = SHUT_OFF;

  // traffic shaping, set per phase
  int gap_max = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_run = 0;

  logic word_taken = 1'b0;
  int fail_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int shut_refusals = 0;

  strict_priority_multi_fifo dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (int'(p) == RING_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // apply one word to the shadow queue and form the result it should give
  function automatic out_word_t priority_queue_outcome(in_word_t w);
    out_word_t r;
    int cls;
    int occ;
    logic [PTR_W-1:0] nt;
    logic [PTR_W-1:0] h;
    logic [PTR_W-1:0] t;
    r = '0;
    cls = int'(w.class_in);
    if (cls >= NUM_CLASSES) cls = NUM_CLASSES - 1;
    if (shut_flag) shut_refusals++;
    if (w.mode == MODE_PUSH) begin
      r.class_out = CLASS_W'(cls);
      if (!shut_flag && w.payload != '0) begin
        nt = next_ptr(tail_ptr[cls]);
        if (nt == head_ptr[cls]) begin
          dropped_cnt++;
        end else begin
          ring_mem[cls][tail_ptr[cls]] = w.payload;
          tail_ptr[cls] = nt;
          pushed_cnt++;
          r.ok = 1'b1;
        end
      end
    end else if (!shut_flag) begin
      // highest non-empty class wins
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
        if (!r.ok && head_ptr[c] != tail_ptr[c]) begin
          r.data_out = ring_mem[c][head_ptr[c]];
          head_ptr[c] = next_ptr(head_ptr[c]);
          popped_cnt++;
          r.ok = 1'b1;
          r.class_out = CLASS_W'(c);
        end
      end
    end
    h = head_ptr[r.class_out];
    t = tail_ptr[r.class_out];
    occ = (t >= h) ? int'(t) - int'(h) : RING_DEPTH - int'(h) + int'(t);
    r.class_count = COUNT_W'(occ);
    r.total_pushed = pushed_cnt;
    r.total_popped = popped_cnt;
    r.total_dropped = dropped_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin : monitor_blk
    out_word_t want;
    word_taken = in_valid && !in_stall;
    if (rst_n) begin
      if (word_taken) begin
        outcome_q.push_back(priority_queue_outcome(in_word));
        words_sent++;
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, got %h",
                   $time, out_word);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("ok", WORD_W'(want.ok), WORD_W'(out_word.ok));
          check_field("data_out", want.data_out, out_word.data_out);
          check_field("class_out", WORD_W'(want.class_out), WORD_W'(out_word.class_out));
          check_field("class_count", WORD_W'(want.class_count),
                      WORD_W'(out_word.class_count));
          check_field("total_pushed", want.total_pushed, out_word.total_pushed);
          check_field("total_popped", want.total_popped, out_word.total_popped);
          check_field("total_dropped", want.total_dropped, out_word.total_dropped);
          results_checked++;
        end
      end
    end
  end

  // driver: bursts of words with gaps, receiver stalls in runs
  always @(negedge clk) begin : driver_blk
    logic next_valid;
    in_word_t next_word;
    next_valid = in_valid;
    next_word = in_word;
    if (word_taken || !in_valid) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0) begin
        next_valid = 1'b1;
        next_word = request_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
    end
    in_valid <= next_valid;
    in_word <= next_word;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(0, 5);
    end
  end

  task automatic queue_word(logic mode, int cls, logic [WORD_W-1:0] payload);
    in_word_t w;
    w.mode = mode;
    w.class_in = CLASS_W'(cls);
    w.payload = payload;
    request_q.push_back(w);
  endtask

  // wait until every word is sent and every result has come back
  task automatic drain();
    while (request_q.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_shutdown(logic value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shut_flag = value;
  endtask

  // random words: push share, optional favored class, mixed payload shapes
  task automatic run_phase(int count, int push_pct, int focus);
    logic mode;
    int cls;
    int pick;
    logic [WORD_W-1:0] payload;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
      cls = (focus >= 0 && $urandom_range(0, 9) < 7) ? focus : $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 5) payload = '0;
      else if (pick < 10) payload = '1;
      else if (pick < 15) payload = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      else payload = $urandom;
      queue_word(mode, cls, payload);
    end
  endtask

  initial begin : stimulus
    int push_pct;
    int focus;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_ptr[c] = '0;
      tail_ptr[c] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, null push, field extremes, fill one ring past full
    gap_max = 2;
    stall_pct = 30;
    queue_word(MODE_POP, 0, '0);
    queue_word(MODE_PUSH, 1, '0);
    queue_word(MODE_PUSH, 0, '1);
    queue_word(MODE_PUSH, 1, 32'h0000_0001);
    queue_word(MODE_PUSH, 2, 32'h8000_0000);
    for (int i = 0; i < RING_DEPTH; i++) begin
      queue_word(MODE_PUSH, 3, WORD_W'(i + 1) * 32'h0101_0101);
    end
    queue_word(MODE_POP, 0, '1);
    drain();

    // shutdown refuses push, pop and null push alike
    write_shutdown(SHUT_ON);
    queue_word(MODE_PUSH, 3, 32'h1234_5678);
    queue_word(MODE_POP, 2, '0);
    queue_word(MODE_PUSH, 1, '0);
    drain();
    write_shutdown(SHUT_OFF);

    // random phases, each ends with a full drain before the next
    for (int p = 0; p < PHASES; p++) begin
      gap_max = (p == 0 || p == 5) ? 0 : $urandom_range(1, 6);
      stall_pct = (p == 0 || p == 5) ? 0 : (p == 10) ? 90 : $urandom_range(10, 70);
      case (p % 4)
        0: begin
          push_pct = 80;
        end
        1: begin
          push_pct = 25;
        end
        2: begin
          push_pct = 55;
        end
        default: begin
          push_pct = 65;
        end
      endcase
      focus = (p % 3 == 0) ? $urandom_range(0, 3) : -1;
      run_phase(PHASE_WORDS, push_pct, focus);
      drain();
      if (p == 3 || p == 8) begin
        write_shutdown(SHUT_ON);
        run_phase(30, 50, -1);
        drain();
        write_shutdown(SHUT_OFF);
      end
    end

    drain();
    $display("run covered %0d words and %0d checked results", words_sent, results_checked);
    $display("%0d stored, %0d served, %0d dropped on full rings, %0d refused in shutdown",
             pushed_cnt, popped_cnt, dropped_cnt, shut_refusals);
    if (fail_count == 0) begin
      $display("strict_priority_multi_fifo test passed");
    end else begin
      $display("strict_priority_multi_fifo test failed");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #400000;
    $display("timeout with %0d results outstanding", outcome_q.size());
    $display("strict_priority_multi_fifo test failed");
    $finish;
  end

endmodule
